@@ design/sync_frame_checksum_deframer_top_macros.svh @@
// assertion macros shared by the deframer rtl
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef SYNC_FRAME_CHECKSUM_DEFRAMER_TOP_MACROS_SVH
`define SYNC_FRAME_CHECKSUM_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define SFCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sfcd_pkg.sv @@
// shared constants and helpers for the sync frame checksum deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfcd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 13;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned INDEX_W       = 4;
  localparam int unsigned SUM_W         = 7;
  localparam int unsigned CNT_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFE;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hFD;
  localparam logic [SUM_W-1:0]  SUM_MODULUS = 7'd127;

  localparam logic [CNT_W-1:0]  CNT_LAST    = CNT_W'(PAYLOAD_BYTES - 1);

  // low bits of the byte position, zero extended when the counter is narrow
  function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+INDEX_W-1:0] wide;
    wide = {{INDEX_W{1'b0}}, cnt};
    return wide[INDEX_W-1:0];
  endfunction

  // (sum + b) mod 127, using 128 = 1 mod 127 to fold the top bits back in
  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] sum,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W:0]  raw;
    logic [SUM_W:0]   fold;
    raw  = {2'b00, sum} + {1'b0, b};
    fold = {1'b0, raw[SUM_W-1:0]} + {{(SUM_W-1){1'b0}}, raw[BYTE_W:SUM_W]};
    if (fold >= {1'b0, SUM_MODULUS}) begin
      fold = fold - {1'b0, SUM_MODULUS};
    end
    return fold[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ design/sfcd_cell.sv @@
// one byte cell of the payload shift chain
// depends on sfcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfcd_cell
  import sfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire logic [BYTE_W-1:0] d,
  output logic      [BYTE_W-1:0] q
);

  // take the neighbor's byte on every shift
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

@@ design/sfcd_chain.sv @@
// row of byte cells holding the payload; bytes enter at the head and
// leave at the tail in arrival order. depends on sfcd_pkg, sfcd_cell
`timescale 1ns / 1ps
`default_nettype none

module sfcd_chain
  import sfcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire logic [BYTE_W-1:0] head,
  output logic      [BYTE_W-1:0] tail
);

  logic [BYTE_W-1:0] link [PAYLOAD_BYTES+1];

  assign link[0] = head;
  assign tail    = link[PAYLOAD_BYTES];

  // cells pass bytes toward the tail together
  for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_cell
    sfcd_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (link[i]),
      .q     (link[i+1])
    );
  end

endmodule

`default_nettype wire

@@ design/sync_frame_checksum_deframer_top.sv @@
// Sync frame checksum deframer.
// Input channel: one received byte per beat on rx_byte (in_valid/in_ready).
// The block hunts for 0xFE, then needs 0xFD (otherwise that byte is dropped
// and hunting restarts), then takes PAYLOAD_BYTES payload bytes into a chain
// of byte cells while summing them modulo 127, then takes the checksum byte.
// Output channel (out_valid/out_ready): on a checksum match the payload is
// sent as PAYLOAD_BYTES beats with payload_index and last_of_frame on the
// final one; on a mismatch one beat with checksum_bad = 1, byte and index 0.
// Throughput: one input beat per cycle while framing. The first result beat
// is valid the cycle after the checksum beat; the burst then moves one beat
// per cycle while out_ready is high, set by the cell chain shifting one
// place per accepted beat. in_ready is low while results are pending, so
// a frame's results are all sent before the next input byte is taken.
// If the receiver stalls, the current beat holds and no input is taken.
// Reset (rst, synchronous) returns the block to hunting with no pending
// results; the payload cells are not cleared and need no clearing time.
// depends on sfcd_pkg, sfcd_chain, sfcd_cell and the macro header
`timescale 1ns / 1ps
`default_nettype none

`include "sync_frame_checksum_deframer_top_macros.svh"

module sync_frame_checksum_deframer_top
  import sfcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [BYTE_W-1:0]  payload_byte,
  output logic      [INDEX_W-1:0] payload_index,
  output logic                    last_of_frame,
  output logic                    checksum_bad
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_PAYLOAD,
    ST_CHECK,
    ST_EMIT,
    ST_ERR
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  sum;

  logic              in_beat;
  logic              out_beat;
  logic              shift;
  logic [BYTE_W-1:0] tail;

  // handshakes
  assign in_ready  = (state != ST_EMIT) && (state != ST_ERR);
  assign out_valid = (state == ST_EMIT) || (state == ST_ERR);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;

  // chain moves on each stored payload byte and each sent result beat
  assign shift = (in_beat && (state == ST_PAYLOAD)) || (out_beat && (state == ST_EMIT));

  sfcd_chain u_chain (
    .clk   (clk),
    .shift (shift),
    .head  (rx_byte),
    .tail  (tail)
  );

  // result fields
  assign checksum_bad  = (state == ST_ERR);
  assign payload_byte  = checksum_bad ? '0 : tail;
  assign payload_index = checksum_bad ? '0 : to_index(cnt);
  assign last_of_frame = checksum_bad || (cnt == CNT_LAST);

  // framing state, byte counter and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
      cnt   <= '0;
      sum   <= '0;
    end else begin
      case (state)
        ST_HUNT: begin
          if (in_beat && (rx_byte == SYNC_FIRST)) begin
            state <= ST_SYNC2;
          end
        end
        ST_SYNC2: begin
          if (in_beat) begin
            cnt   <= '0;
            sum   <= '0;
            state <= (rx_byte == SYNC_SECOND) ? ST_PAYLOAD : ST_HUNT;
          end
        end
        ST_PAYLOAD: begin
          if (in_beat) begin
            sum <= sum_add(sum, rx_byte);
            if (cnt == CNT_LAST) begin
              cnt   <= '0;
              state <= ST_CHECK;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_CHECK: begin
          if (in_beat) begin
            cnt   <= '0;
            sum   <= '0;
            state <= (rx_byte == {1'b0, sum}) ? ST_EMIT : ST_ERR;
          end
        end
        ST_EMIT: begin
          if (out_beat) begin
            if (cnt == CNT_LAST) begin
              cnt   <= '0;
              state <= ST_HUNT;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        ST_ERR: begin
          if (out_beat) begin
            state <= ST_HUNT;
          end
        end
        default: begin
          state <= ST_HUNT;
          cnt   <= '0;
          sum   <= '0;
        end
      endcase
    end
  end

  // checks
  `SFCD_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input taken while results pending")
  `SFCD_ASSERT_NOW(a_err_beat, checksum_bad, last_of_frame && (payload_index == '0) && (payload_byte == '0), "error beat fields wrong")
  `SFCD_ASSERT_NEXT(a_back_to_hunt, out_beat && last_of_frame, (state == ST_HUNT) && in_ready, "no return to hunting after frame")
  `SFCD_ASSERT_NEXT(a_payload_end, in_beat && (state == ST_PAYLOAD) && (cnt == CNT_LAST), state == ST_CHECK, "checksum phase not entered")

endmodule

`default_nettype wire

@@ verif/frame_result_checker.sv @@
// result checker for the sync frame checksum deframer: predicts the beats of each frame
// from the received bytes and compares them with the output channel
// depends on sfcd_pkg
`timescale 1ns / 1ps

module frame_result_checker
  import sfcd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [BYTE_W-1:0]  rx_byte,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [BYTE_W-1:0]  payload_byte,
  input  wire logic [INDEX_W-1:0] payload_index,
  input  wire logic               last_of_frame,
  input  wire logic               checksum_bad,
  output int                      errors,
  output int                      pending
);

  localparam int unsigned CHECK_MODULUS = SUM_MODULUS;
  localparam int          REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    HUNT,
    WANT_SECOND,
    IN_PAYLOAD,
    WANT_CHECKSUM
  } hunt_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               bad;
  } result_beat_t;

  hunt_phase_t       phase;
  int unsigned       bytes_stored;
  int unsigned       running_sum;
  logic [BYTE_W-1:0] frame_bytes [PAYLOAD_BYTES];
  result_beat_t      expected_beats [$];

  // advance the framing state by one received byte, queue any beats it releases
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    result_beat_t beat;
    case (phase)
      HUNT: begin
        if (b == SYNC_FIRST) phase = WANT_SECOND;
      end
      WANT_SECOND: begin
        // anything but the second sync byte is swallowed, a repeated first one too
        if (b == SYNC_SECOND) begin
          phase        = IN_PAYLOAD;
          bytes_stored = 0;
          running_sum  = 0;
        end else begin
          phase = HUNT;
        end
      end
      IN_PAYLOAD: begin
        if (bytes_stored < PAYLOAD_BYTES) frame_bytes[bytes_stored] = b;
        running_sum = (running_sum + b) % CHECK_MODULUS;
        bytes_stored++;
        if (bytes_stored >= PAYLOAD_BYTES) phase = WANT_CHECKSUM;
      end
      default: begin
        if (b == running_sum) begin
          for (int unsigned i = 0; i < PAYLOAD_BYTES; i++) begin
            beat.data  = frame_bytes[i];
            beat.index = INDEX_W'(i);
            beat.last  = (i + 1 == PAYLOAD_BYTES);
            beat.bad   = 1'b0;
            expected_beats.push_back(beat);
          end
        end else begin
          // dropped frame: a single error beat
          beat.data  = '0;
          beat.index = '0;
          beat.last  = 1'b1;
          beat.bad   = 1'b1;
          expected_beats.push_back(beat);
        end
        phase        = HUNT;
        bytes_stored = 0;
        running_sum  = 0;
      end
    endcase
  endtask

  // count a failure, print only the first few
  task automatic flag_failure(input string what, input result_beat_t want,
                              input result_beat_t got);
    if (errors < REPORT_LIMIT) begin
      $display("%0t %s: expected byte %h index %0d last %b bad %b, got byte %h index %0d last %b bad %b",
               $realtime, what, want.data, want.index, want.last, want.bad,
               got.data, got.index, got.last, got.bad);
    end
    errors++;
  endtask

  // compare one output beat with the oldest prediction
  task automatic compare_beat(input result_beat_t got);
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      want = '0;
      flag_failure("unexpected beat", want, got);
    end else begin
      want = expected_beats.pop_front();
      if (got.data !== want.data || got.index !== want.index ||
          got.last !== want.last || got.bad !== want.bad) begin
        flag_failure("mismatch", want, got);
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    result_beat_t got;
    if (rst) begin
      phase        = HUNT;
      bytes_stored = 0;
      running_sum  = 0;
      errors       = 0;
      expected_beats.delete();
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (out_valid && out_ready) begin
        got.data  = payload_byte;
        got.index = payload_index;
        got.last  = last_of_frame;
        got.bad   = checksum_bad;
        compare_beat(got);
      end
    end
    pending = expected_beats.size();
  end

endmodule

@@ verif/testbench.sv @@
// top of the deframer testbench: clock, reset, byte stimulus and output back-pressure
// depends on sfcd_pkg, sync_frame_checksum_deframer_top and frame_result_checker
`timescale 1ns / 1ps

module testbench;
  import sfcd_pkg::*;

  localparam int FILL_RANDOM      = 0;
  localparam int FILL_ONES        = 1;
  localparam int FILL_ZEROS       = 2;
  localparam int CKS_GOOD         = 0;
  localparam int CKS_WRONG        = 1;
  localparam int CKS_HIGH         = 2;
  localparam int FRAMED_TARGET    = 220;
  localparam int LONG_HOLD_AT     = 20;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int DRAIN_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 20;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [BYTE_W-1:0]  rx_byte   = '0;
  logic               out_ready = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire  [BYTE_W-1:0]  payload_byte;
  wire  [INDEX_W-1:0] payload_index;
  wire                last_of_frame;
  wire                checksum_bad;
  int                 errors;
  int                 pending;
  bit                 calm = 1'b0;
  int unsigned        framed_bytes = 0;

  always #5 clk = ~clk;

  sync_frame_checksum_deframer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .last_of_frame (last_of_frame),
    .checksum_bad  (checksum_bad)
  );

  frame_result_checker u_result_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .last_of_frame (last_of_frame),
    .checksum_bad  (checksum_bad),
    .errors        (errors),
    .pending       (pending)
  );

  // offer one byte after a random gap, return at the edge that takes the beat
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // sync pair, payload and checksum byte
  task automatic send_frame(input int fill, input int cks_mode);
    logic [BYTE_W-1:0] b;
    int unsigned       sum;
    sum = 0;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (fill == FILL_ONES) b = '1;
      else if (fill == FILL_ZEROS) b = '0;
      else begin
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = '1;
          default: b = BYTE_W'($urandom_range(0, 255));
        endcase
      end
      sum = (sum + b) % SUM_MODULUS;
      send_byte(b);
    end
    // checksums of 127 and up can never match
    if (cks_mode == CKS_GOOD) b = BYTE_W'(sum);
    else if (cks_mode == CKS_WRONG) b = BYTE_W'((sum + $urandom_range(1, 126)) % SUM_MODULUS);
    else b = BYTE_W'($urandom_range(127, 255));
    send_byte(b);
    framed_bytes += PAYLOAD_BYTES + 3;
  endtask

  // byte stimulus and verdict
  initial begin
    int unsigned       pick;
    int unsigned       waited;
    logic [BYTE_W-1:0] b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // noise at both extremes, a broken sync pair, a doubled first sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_frame(FILL_ONES, CKS_GOOD);
    send_frame(FILL_ZEROS, CKS_HIGH);

    // mostly well formed frames, some bad checksums, noise and broken syncs
    while (framed_bytes < FRAMED_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 5) send_frame(FILL_RANDOM, CKS_GOOD);
      else if (pick == 6) send_frame(FILL_RANDOM, CKS_WRONG);
      else if (pick == 7) send_frame(FILL_RANDOM, CKS_HIGH);
      else if (pick == 8) begin
        repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_byte(SYNC_FIRST);
        b = BYTE_W'($urandom_range(0, 255));
        if (b == SYNC_SECOND) b = SYNC_FIRST;
        send_byte(b);
        framed_bytes += 2;
      end
    end
    in_valid <= 1'b0;

    // drain outstanding result beats
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // output back-pressure, with one long hold-off that backs up the input
  initial begin
    int unsigned stall;
    int unsigned beats;
    beats = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (beats == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      else stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      beats++;
    end
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
